// ----- rtl/btbc_pkg.sv -----
// btbc_pkg: shared types and constants of the chained branch target buffer
// used by the cell, the cell row and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package btbc_pkg;

    // fixed width of the address fields on the ports
    localparam int FIELD_W   = 64;
    // width of the chain position field
    localparam int SLOT_W    = 3;
    // fall-through step when no entry matches
    localparam int NEXT_STEP = 4;

    typedef logic [SLOT_W-1:0] t_slot;

    // per-cell control from the row
    typedef struct packed {
        logic load;   // take the entry of the neighbour below
        logic clear;  // flush the entry to zero
    } t_cell_ctrl;

    // update request from the sequencer to the row
    typedef struct packed {
        logic apply;  // update requested this cycle
        logic flush;  // clear the table this cycle
        logic exe;    // executed flag of the update
    } t_upd_req;

endpackage

`default_nettype wire

// ----- rtl/btbc_cell.sv -----
// btbc_cell: one table entry with its tag comparator
// depends on btbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module btbc_cell #(
    parameter int ADDR_BITS = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire btbc_pkg::t_cell_ctrl   i_ctrl,
    input  wire logic [ADDR_BITS-1:0]   i_key,
    input  wire logic [ADDR_BITS-1:0]   i_tag,
    input  wire logic [ADDR_BITS-1:0]   i_target,
    input  wire logic                   i_exec,
    output logic      [ADDR_BITS-1:0]   o_tag,
    output logic      [ADDR_BITS-1:0]   o_target,
    output logic                        o_exec,
    output logic                        o_hit
);

    logic [ADDR_BITS-1:0] r_tag;
    logic [ADDR_BITS-1:0] r_target;
    logic                 r_exec;

    // entry storage: flush and reset clear, load shifts in from below
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_tag    <= '0;
            r_target <= '0;
            r_exec   <= 1'b0;
        end else if (i_ctrl.load) begin
            r_tag    <= i_tag;
            r_target <= i_target;
            r_exec   <= i_exec;
        end
    end

    // tag compare against the broadcast key
    assign o_hit    = (r_tag == i_key);
    assign o_tag    = r_tag;
    assign o_target = r_target;
    assign o_exec   = r_exec;

endmodule

`default_nettype wire

// ----- rtl/btbc_row.sv -----
// btbc_row: row of entry cells with lookup select and move-to-front update
// depends on btbc_pkg and btbc_cell
`timescale 1ns / 1ps
`default_nettype none

module btbc_row #(
    parameter int ENTRIES   = 8,
    parameter int ADDR_BITS = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [ADDR_BITS-1:0]   i_key,
    input  wire btbc_pkg::t_upd_req     i_upd,
    input  wire logic [ADDR_BITS-1:0]   i_wtarget,
    output logic                        o_lk_hit,
    output logic      [ADDR_BITS-1:0]   o_lk_target,
    output logic                        o_lk_exec
);

    logic [ADDR_BITS-1:0] w_tag    [ENTRIES];
    logic [ADDR_BITS-1:0] w_target [ENTRIES];
    logic [ENTRIES-1:0]   w_exec;
    logic [ENTRIES-1:0]   w_hit;
    logic [ENTRIES-1:0]   w_below;
    logic [ENTRIES-1:0]   w_above;
    logic                 w_hi_exec;
    logic                 w_blocked;
    btbc_pkg::t_cell_ctrl w_ctrl [ENTRIES];

    // the cells, each fed by its lower neighbour; cell 0 takes the new entry
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            btbc_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctrl   (w_ctrl[g]),
                .i_key    (i_key),
                .i_tag    (i_key),
                .i_target (i_wtarget),
                .i_exec   (i_upd.exe),
                .o_tag    (w_tag[g]),
                .o_target (w_target[g]),
                .o_exec   (w_exec[g]),
                .o_hit    (w_hit[g])
            );
        end else begin : g_body
            btbc_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctrl   (w_ctrl[g]),
                .i_key    (i_key),
                .i_tag    (w_tag[g-1]),
                .i_target (w_target[g-1]),
                .i_exec   (w_exec[g-1]),
                .o_tag    (w_tag[g]),
                .o_target (w_target[g]),
                .o_exec   (w_exec[g]),
                .o_hit    (w_hit[g])
            );
        end
    end

    // hits below and above each cell
    always_comb begin
        w_below[0] = 1'b0;
        for (int i = 1; i < ENTRIES; i++) begin
            w_below[i] = w_below[i-1] | w_hit[i-1];
        end
        w_above[ENTRIES-1] = 1'b0;
        for (int i = ENTRIES - 2; i >= 0; i--) begin
            w_above[i] = w_above[i+1] | w_hit[i+1];
        end
    end

    // lowest match drives the lookup, highest match gives the block flag
    always_comb begin
        o_lk_target = '0;
        o_lk_exec   = 1'b0;
        w_hi_exec   = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_hit[i] && !w_below[i]) begin
                o_lk_target = o_lk_target | w_target[i];
                o_lk_exec   = o_lk_exec | w_exec[i];
            end
            if (w_hit[i] && !w_above[i]) begin
                w_hi_exec = w_hi_exec | w_exec[i];
            end
        end
    end

    assign o_lk_hit  = |w_hit;
    assign w_blocked = w_hi_exec & ~i_upd.exe;

    // shift cells up to and including the first match; flush clears all
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_ctrl[i].load  = i_upd.apply & ~w_blocked & ~w_below[i];
            w_ctrl[i].clear = i_upd.flush;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/branch_target_buffer_chained_top.sv -----
// the first prediction is registered by the first chain step after the request
// a request is taken in the idle state; its chain then does one lookup in the
// cell row per chain position
// the update and flush land in the cycle that registers the final prediction
// a new request is taken once the final prediction of the chain is registered
// reset (synchronous, active low) clears every entry and the control state
// depends on btbc_pkg and btbc_row
`timescale 1ns / 1ps
`default_nettype none

module branch_target_buffer_chained_top #(
    parameter int ENTRIES     = 8,
    parameter int CHAIN_DEPTH = 5,
    parameter int ADDR_BITS   = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [btbc_pkg::FIELD_W-1:0]  i_fetch_addr,
    input  wire logic                          i_executed,
    input  wire logic                          i_write_en,
    input  wire logic [btbc_pkg::FIELD_W-1:0]  i_write_addr,
    input  wire logic [btbc_pkg::FIELD_W-1:0]  i_write_target,
    input  wire logic                          i_flush,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [btbc_pkg::SLOT_W-1:0]   o_slot,
    output logic      [btbc_pkg::FIELD_W-1:0]  o_pred_addr,
    output logic                               o_pred_executed,
    output logic                               o_last
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    localparam btbc_pkg::t_slot LastSlot = btbc_pkg::t_slot'(CHAIN_DEPTH - 1);

    t_state               r_state;
    btbc_pkg::t_slot      r_k;
    logic [ADDR_BITS-1:0] r_cur;
    logic                 r_cur_exec;
    logic                 r_exe;
    logic                 r_we;
    logic                 r_flush;
    logic [ADDR_BITS-1:0] r_waddr;
    logic [ADDR_BITS-1:0] r_wtarget;
    logic                 r_out_valid;
    btbc_pkg::t_slot      r_slot;
    logic [ADDR_BITS-1:0] r_pred_addr;
    logic                 r_pred_exec;
    logic                 r_last;

    logic                 w_step;
    logic                 w_is_last;
    logic [ADDR_BITS-1:0] w_key;
    logic                 w_lk_hit;
    logic [ADDR_BITS-1:0] w_lk_target;
    logic                 w_lk_exec;
    btbc_pkg::t_upd_req   w_upd;

    // a chain step moves whenever the output register is free or drained
    assign w_step    = (r_state == S_RUN) && (!r_out_valid || i_out_ready);
    assign w_is_last = (r_k == LastSlot);
    // final step probes the update tag instead of the chain address
    assign w_key     = w_is_last ? r_waddr : r_cur;

    assign w_upd.apply = w_step & w_is_last & r_we;
    assign w_upd.flush = w_step & w_is_last & r_flush;
    assign w_upd.exe   = r_exe;

    btbc_row #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (w_key),
        .i_upd       (w_upd),
        .i_wtarget   (r_wtarget),
        .o_lk_hit    (w_lk_hit),
        .o_lk_target (w_lk_target),
        .o_lk_exec   (w_lk_exec)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (i_in_valid) begin
                        r_state    <= S_RUN;
                        r_k        <= '0;
                        r_cur      <= i_fetch_addr[ADDR_BITS-1:0];
                        r_cur_exec <= i_executed;
                        r_exe      <= i_executed;
                        r_we       <= i_write_en;
                        r_flush    <= i_flush;
                        r_waddr    <= i_write_addr[ADDR_BITS-1:0];
                        r_wtarget  <= i_write_target[ADDR_BITS-1:0];
                    end
                end
                S_RUN: begin
                    if (w_step) begin
                        r_out_valid <= 1'b1;
                        r_slot      <= r_k;
                        r_pred_addr <= r_cur;
                        r_pred_exec <= r_cur_exec;
                        r_last      <= w_is_last;
                        if (w_is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k        <= r_k + 1'b1;
                            r_cur      <= w_lk_hit ? w_lk_target
                                        : r_cur + ADDR_BITS'(btbc_pkg::NEXT_STEP);
                            r_cur_exec <= w_lk_hit & w_lk_exec;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_slot          = r_slot;
    assign o_pred_addr     = btbc_pkg::FIELD_W'(r_pred_addr);
    assign o_pred_executed = r_pred_exec;
    assign o_last          = r_last;

endmodule

`default_nettype wire

// ----- rtl/btbc_checker.sv -----
// btbc_checker: port-level assertions on the chained branch target buffer
// bound to branch_target_buffer_chained_top; depends on btbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module btbc_checker #(
    parameter int CHAIN_DEPTH = 5
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [btbc_pkg::SLOT_W-1:0]   o_slot,
    input wire logic [btbc_pkg::FIELD_W-1:0]  o_pred_addr,
    input wire logic                          o_last
);

    localparam btbc_pkg::t_slot LastSlot = btbc_pkg::t_slot'(CHAIN_DEPTH - 1);

    // a stalled prediction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pred_addr)
            && $stable(o_slot))
        else $error("stalled prediction changed");

    // a taken request closes the input until its chain is out
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while chain busy");

    // the final prediction sits at the last chain position
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_slot == LastSlot)
        else $error("final prediction at wrong position");

    // a drained non-final prediction is followed at once by the next position
    a_next_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=>
            o_out_valid && o_slot == $past(o_slot) + 1'b1)
        else $error("chain position skipped");

    // no new request while a chain is partly out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("request taken mid chain");

endmodule

bind branch_target_buffer_chained_top btbc_checker #(
    .CHAIN_DEPTH (CHAIN_DEPTH)
) u_btbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_slot      (o_slot),
    .o_pred_addr (o_pred_addr),
    .o_last      (o_last)
);

`default_nettype wire

// ----- tb/branch_target_buffer_chained_top_tb.sv -----
// testbench for the chained branch target buffer: directed and random requests,
// each prediction chain checked against a local model of the table
// depends on btbc_pkg and branch_target_buffer_chained_top
`timescale 1ns / 1ps

module branch_target_buffer_chained_top_tb;

    localparam int FIELD_W   = btbc_pkg::FIELD_W;
    localparam int SLOT_W    = btbc_pkg::SLOT_W;
    localparam int NEXT_STEP = btbc_pkg::NEXT_STEP;

    typedef btbc_pkg::t_slot t_slot;

    localparam int ENTRIES      = 8;
    localparam int CHAIN_DEPTH  = 5;
    localparam int ADDR_BITS    = 64;
    localparam int N_RANDOM     = 306;
    localparam int POOL_SIZE    = 16;
    localparam int CALM_TAIL    = 40;
    localparam int HOLD_START   = 60;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [FIELD_W-1:0] ALL_ONES  = '1;
    localparam logic [FIELD_W-1:0] ADDR_MASK = ALL_ONES >> (FIELD_W - ADDR_BITS);
    localparam logic [FIELD_W-1:0] BR_A = 64'h0000_0000_8000_1000;
    localparam logic [FIELD_W-1:0] BR_B = 64'h0000_0000_8000_2040;
    localparam logic [FIELD_W-1:0] BR_C = 64'h0000_0000_8000_3080;
    localparam logic [FIELD_W-1:0] BR_D = 64'h0000_0000_8000_40c0;
    localparam logic [FIELD_W-1:0] BR_E = 64'h7fff_0000_0000_0100;

    typedef struct packed {
        logic [FIELD_W-1:0] fetch_addr;
        logic               executed;
        logic               write_en;
        logic [FIELD_W-1:0] write_addr;
        logic [FIELD_W-1:0] write_target;
        logic               flush;
    } t_req;

    typedef struct packed {
        t_slot              slot;
        logic [FIELD_W-1:0] addr;
        logic               exec;
        logic               last;
    } t_pred;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_req cur_req     = '0;

    wire logic                o_in_ready;
    wire logic                o_out_valid;
    wire logic [SLOT_W-1:0]   o_slot;
    wire logic [FIELD_W-1:0]  o_pred_addr;
    wire logic                o_pred_executed;
    wire logic                o_last;

    // request queue, expected chain and local copy of the table
    t_req               req_q[$];
    t_pred              chain_q[$];
    logic [FIELD_W-1:0] tbl_tag[ENTRIES];
    logic [FIELD_W-1:0] tbl_target[ENTRIES];
    logic               tbl_exec[ENTRIES];
    logic [FIELD_W-1:0] addr_pool[POOL_SIZE];

    logic req_taken   = 1'b0;
    logic hold_active = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_cnt    = 0;
    int   n_taken     = 0;
    int   n_total     = 0;
    int   n_preds     = 0;
    int   n_updates   = 0;
    int   n_blocked   = 0;
    int   n_flushes   = 0;
    int   n_hits      = 0;
    int   err_cnt     = 0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    int   cycle_cnt   = 0;

    branch_target_buffer_chained_top #(
        .ENTRIES     (ENTRIES),
        .CHAIN_DEPTH (CHAIN_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_fetch_addr    (cur_req.fetch_addr),
        .i_executed      (cur_req.executed),
        .i_write_en      (cur_req.write_en),
        .i_write_addr    (cur_req.write_addr),
        .i_write_target  (cur_req.write_target),
        .i_flush         (cur_req.flush),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_slot          (o_slot),
        .o_pred_addr     (o_pred_addr),
        .o_pred_executed (o_pred_executed),
        .o_last          (o_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [FIELD_W-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_req(input logic [FIELD_W-1:0] fetch, input logic exe,
                           input logic we, input logic [FIELD_W-1:0] waddr,
                           input logic [FIELD_W-1:0] wtarget, input logic fl);
        t_req r;
        r = '{fetch, exe, we, waddr, wtarget, fl};
        req_q.push_back(r);
        n_total++;
    endtask

    // address pool: extremes, a run of neighbouring words so chains hit, a few strays
    task automatic fill_pool();
        logic [FIELD_W-1:0] base;
        base = rnd64() & ~FIELD_W'(3);
        addr_pool[0] = '0;
        addr_pool[1] = ALL_ONES;
        addr_pool[2] = ALL_ONES - 3;
        for (int k = 3; k < POOL_SIZE - 3; k++)
            addr_pool[k] = base + FIELD_W'(4 * (k - 3));
        for (int k = POOL_SIZE - 3; k < POOL_SIZE; k++)
            addr_pool[k] = rnd64();
    endtask

    function automatic logic [FIELD_W-1:0] pick_addr();
        return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // chain lookup on the old table, then update and flush
    task automatic predict_chain(input t_req r);
        logic [FIELD_W-1:0] cur;
        logic [FIELD_W-1:0] nxt;
        logic               cur_exec;
        logic               nexec;
        logic               hit;
        logic               blocked;
        logic [FIELD_W-1:0] waddr;
        int                 first;
        int                 top;
        t_pred              p;
        cur      = r.fetch_addr & ADDR_MASK;
        cur_exec = r.executed;
        for (int k = 0; k < CHAIN_DEPTH; k++) begin
            if (k > 0) begin
                hit   = 1'b0;
                nxt   = (cur + FIELD_W'(NEXT_STEP)) & ADDR_MASK;
                nexec = 1'b0;
                // lowest-index match wins
                for (int n = 0; n < ENTRIES; n++) begin
                    if (!hit && tbl_tag[n] == cur) begin
                        hit   = 1'b1;
                        nxt   = tbl_target[n];
                        nexec = tbl_exec[n];
                    end
                end
                if (hit) n_hits++;
                cur      = nxt;
                cur_exec = nexec;
            end
            p.slot = t_slot'(k);
            p.addr = cur;
            p.exec = cur_exec;
            p.last = (k == CHAIN_DEPTH - 1);
            chain_q.push_back(p);
        end

        if (r.write_en) begin
            waddr   = r.write_addr & ADDR_MASK;
            first   = -1;
            blocked = 1'b0;
            // the highest-index match decides blocking
            for (int n = 0; n < ENTRIES; n++) begin
                if (tbl_tag[n] == waddr) begin
                    if (first < 0) first = n;
                    blocked = tbl_exec[n] && !r.executed;
                end
            end
            if (blocked) begin
                n_blocked++;
            end else begin
                n_updates++;
                top = (first < 0) ? ENTRIES - 1 : first;
                for (int n = top; n > 0; n--) begin
                    tbl_tag[n]    = tbl_tag[n-1];
                    tbl_target[n] = tbl_target[n-1];
                    tbl_exec[n]   = tbl_exec[n-1];
                end
                tbl_tag[0]    = waddr;
                tbl_target[0] = r.write_target & ADDR_MASK;
                tbl_exec[0]   = r.executed;
            end
        end

        if (r.flush) begin
            n_flushes++;
            for (int n = 0; n < ENTRIES; n++) begin
                tbl_tag[n]    = '0;
                tbl_target[n] = '0;
                tbl_exec[n]   = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                   input logic [FIELD_W-1:0] want);
        $display("prediction %0d: %s is %h, expected %h", n_preds, what, got, want);
        err_cnt++;
    endtask

    // stimulus, reset and end of run
    initial begin : stimulus
        t_req r;
        for (int n = 0; n < ENTRIES; n++) begin
            tbl_tag[n]    = '0;
            tbl_target[n] = '0;
            tbl_exec[n]   = 1'b0;
        end

        // zero tags from reset, wrap past the top of the address space
        add_req('0, 1'b0, 1'b0, '0, '0, 1'b0);
        add_req(ALL_ONES, 1'b1, 1'b0, '0, '0, 1'b0);
        // tag zero written while duplicate zero tags remain, lowest index wins
        add_req('0, 1'b1, 1'b1, '0, BR_A, 1'b0);
        add_req('0, 1'b0, 1'b0, '0, '0, 1'b0);
        // build a short chain and walk it
        add_req(BR_A, 1'b1, 1'b1, BR_A, BR_B, 1'b0);
        add_req(BR_B, 1'b0, 1'b1, BR_B, BR_C, 1'b0);
        add_req(BR_A, 1'b0, 1'b0, '0, '0, 1'b0);
        // update blocked by an executed entry, then allowed and moved to front
        add_req(BR_A, 1'b0, 1'b1, BR_A, BR_D, 1'b0);
        add_req(BR_A, 1'b1, 1'b1, BR_A, BR_D, 1'b0);
        add_req(BR_A, 1'b0, 1'b0, '0, '0, 1'b0);
        // overfill the table so the oldest entry drops out
        for (int k = 0; k < ENTRIES + 1; k++)
            add_req(BR_E, k[0], 1'b1, BR_E + FIELD_W'(4 * k), BR_E + FIELD_W'(4 * (k + 1)),
                    1'b0);
        // all-ones entry, flush together with an update
        add_req(ALL_ONES, 1'b1, 1'b1, ALL_ONES, ALL_ONES, 1'b0);
        add_req(ALL_ONES, 1'b0, 1'b0, '0, '0, 1'b0);
        add_req(BR_A, 1'b1, 1'b1, BR_C, BR_A, 1'b1);
        add_req(BR_C, 1'b0, 1'b0, '0, '0, 1'b0);
        add_req(64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b1, 64'h5555_5555_5555_5555,
                64'haaaa_aaaa_aaaa_aaaa, 1'b0);

        // random requests, mostly drawn from the pool so chains follow entries
        fill_pool();
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) fill_pool();
            if ($urandom_range(0, 9) == 0) begin
                r.fetch_addr   = rnd64();
                r.executed     = 1'($urandom_range(0, 1));
                r.write_en     = 1'($urandom_range(0, 1));
                r.write_addr   = rnd64();
                r.write_target = rnd64();
                r.flush        = 1'($urandom_range(0, 1));
            end else begin
                r.fetch_addr   = pick_addr();
                r.executed     = 1'($urandom_range(0, 1));
                r.write_en     = ($urandom_range(0, 9) < 6);
                r.write_addr   = pick_addr();
                r.write_target = ($urandom_range(0, 6) == 0) ? rnd64() : pick_addr();
                r.flush        = ($urandom_range(0, 39) == 0);
            end
            req_q.push_back(r);
            n_total++;
        end

        // synchronous reset, released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken != n_total || chain_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d requests, %0d predictions checked, %0d chain hits", n_total, n_preds,
                 n_hits);
        $display("%0d updates applied, %0d blocked, %0d flushes, one long receiver hold",
                 n_updates, n_blocked, n_flushes);
        if (err_cnt == 0)
            $display("branch_target_buffer_chained_top test passed");
        else
            $display("branch_target_buffer_chained_top test failed");
        $finish;
    end

    // request driver, random gaps except during the hold and the tail
    always @(negedge i_clk) begin : sender
        logic offer;
        t_req nxt;
        offer = i_in_valid && !req_taken;
        nxt   = cur_req;
        if (i_rst_n && !offer) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_q.size() != 0) begin
                if (!hold_active && n_taken < n_total - CALM_TAIL && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 12) - 1;
                else begin
                    nxt   = req_q.pop_front();
                    offer = 1'b1;
                end
            end
        end
        i_in_valid <= offer;
        cur_req    <= nxt;
    end

    // result acceptor, random stalls and the long hold
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n || hold_active) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (n_taken < n_total - CALM_TAIL && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // long hold-off once, so the block backs up and stalls its input
    always @(posedge i_clk) begin : pressure
        if (!hold_done && !hold_active && n_taken >= HOLD_START) begin
            hold_active <= 1'b1;
            hold_cnt    <= 0;
        end else if (hold_active) begin
            if (hold_cnt == HOLD_CYCLES - 1) begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end
            hold_cnt <= hold_cnt + 1;
        end
    end

    // monitor: check each prediction, then predict any request taken
    always @(posedge i_clk) begin : monitor
        t_pred want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (chain_q.size() == 0) begin
                    report_mismatch("unexpected pred_addr", o_pred_addr, '0);
                end else begin
                    want = chain_q.pop_front();
                    if (o_slot !== want.slot)
                        report_mismatch("slot", FIELD_W'(o_slot), FIELD_W'(want.slot));
                    if (o_pred_addr !== want.addr)
                        report_mismatch("pred_addr", o_pred_addr, want.addr);
                    if (o_pred_executed !== want.exec)
                        report_mismatch("pred_executed", FIELD_W'(o_pred_executed),
                                        FIELD_W'(want.exec));
                    if (o_last !== want.last)
                        report_mismatch("last", FIELD_W'(o_last), FIELD_W'(want.last));
                end
                n_preds++;
            end
            if (i_in_valid && o_in_ready) begin
                predict_chain(cur_req);
                n_taken <= n_taken + 1;
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("branch_target_buffer_chained_top test failed");
            $finish;
        end
    end

endmodule

// ----- branch_target_buffer_chained_top.f -----
rtl/btbc_pkg.sv
rtl/btbc_cell.sv
rtl/btbc_row.sv
rtl/branch_target_buffer_chained_top.sv
rtl/btbc_checker.sv
tb/branch_target_buffer_chained_top_tb.sv
